// File: rtl/core/sea_pkg.sv
// ----------------------------------------------------------------------------
// sea_pkg: shared constants for the sliding and exponential average core
// Sizes of the sample window, the running sum and the shared divider.
// ----------------------------------------------------------------------------
package sea_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int PRICE_BITS = 32;

   // Window length register and the write position into the sample ring.
   localparam int N_W   = $clog2(MAX_WINDOW + 1);
   localparam int POS_W = $clog2(MAX_WINDOW);

   // The running sum must hold MAX_WINDOW full-scale samples.
   localparam int SUM_W = PRICE_BITS + $clog2(MAX_WINDOW);

   // The divider divides by N or by N + 1.
   localparam int DVS_W = $clog2(MAX_WINDOW + 2);
   localparam int CNT_W = $clog2(SUM_W);

   localparam logic [N_W-1:0] WINDOW_RESET = N_W'(20);

endpackage

// File: rtl/core/sliding_and_exponential_average_core.sv
// ----------------------------------------------------------------------------
// sliding_and_exponential_average_core: simple and exponential moving average
// Keeps the last N price words, their sum and an exponential average, and
// gives both averages once the window has filled.
// ----------------------------------------------------------------------------
// Usage: each price word accepted on the req_ channel goes into a ring of the
// last N words (N is csr_window_length, with zero read as one and anything
// above MAX_WINDOW read as MAX_WINDOW). Until N words have arrived since the
// last clear, a word gives no result. From then on
// every word gives one result word on the rsp_ channel: floor(sum / N) and an
// exponential average with weight 2/(N+1), seeded with the first simple
// average. Both quotients come out of one restoring divider that retires one
// quotient bit a cycle over the full width of the running sum (38 steps). It
// runs once for an item that seeds the average and twice once the window is
// full, for the simple and then the exponential quotient. The block takes no
// new word while one is in work, but a finished result waits in an output
// register, so the next word may be accepted before that result is taken.
// If the previous result word is still held there when the next one is
// finished, the sequencer waits until it has been taken, which adds those
// stalled cycles to the item.
// Reset and every write to the window length clear the sum, the fill count,
// the write position and the exponential average; the sample ring itself is
// not cleared, as no stale entry is ever read. Writes should be made only
// while the block is idle.
module sliding_and_exponential_average_core
   import sea_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_write_en,
   input  logic [N_W-1:0]        csr_window_length,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PRICE_BITS-1:0] req_price,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PRICE_BITS-1:0] rsp_simple_average,
   output logic [PRICE_BITS-1:0] rsp_exponential_average
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_READ    = 3'd1;
   localparam logic [2:0] ST_SUM     = 3'd2;
   localparam logic [2:0] ST_SMA_DIV = 3'd3;
   localparam logic [2:0] ST_SMA_END = 3'd4;
   localparam logic [2:0] ST_EMA_DIV = 3'd5;
   localparam logic [2:0] ST_EMA_END = 3'd6;
   localparam logic [2:0] ST_DONE    = 3'd7;

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SUM_W - 1);

   // Control state.
   logic [2:0]       state_ff, state_in;
   logic [N_W-1:0]   window_ff, window_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [N_W-1:0]   fill_ff, fill_in;
   logic [POS_W-1:0] wpos_ff, wpos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Working and payload registers.
   logic [PRICE_BITS-1:0] ema_ff, ema_in;
   logic [PRICE_BITS-1:0] price_ff, price_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  was_full_ff, was_full_in;
   logic                  up_ff, up_in;
   logic [PRICE_BITS-1:0] sma_ff, sma_in;
   logic [SUM_W-1:0]      quot_ff, quot_in;
   logic [DVS_W-1:0]      rem_ff, rem_in;
   logic [DVS_W-1:0]      dvs_ff, dvs_in;
   logic [PRICE_BITS-1:0] out_sma_ff, out_sma_in;
   logic [PRICE_BITS-1:0] out_ema_ff, out_ema_in;

   // Sample ring.
   logic [PRICE_BITS-1:0] ring_mem [MAX_WINDOW];
   logic [PRICE_BITS-1:0] ring_rd_ff;

   // Combinational helpers.
   logic [N_W-1:0]        n_eff;
   logic [N_W-1:0]        next_pos;
   logic [N_W-1:0]        fill_inc;
   logic [SUM_W-1:0]      new_sum;
   logic [DVS_W:0]        trial;
   logic                  trial_ge;
   logic [PRICE_BITS-1:0] diff;
   logic                  out_free;

   // The usable window length.
   always_comb begin
      if (window_ff == '0) begin
         n_eff = N_W'(1);
      end else if (window_ff > N_W'(MAX_WINDOW)) begin
         n_eff = N_W'(MAX_WINDOW);
      end else begin
         n_eff = window_ff;
      end
   end

   // One step of the restoring divider: shift in the next dividend bit and
   // subtract the divisor where it fits.
   assign trial    = {rem_ff, quot_ff[SUM_W-1]};
   assign trial_ge = (trial >= {1'b0, dvs_ff});

   assign next_pos = N_W'(pos_ff) + N_W'(1);
   assign fill_inc = fill_ff + N_W'(1);
   assign new_sum  = sum_ff - (was_full_ff ? SUM_W'(ring_rd_ff) : '0) + SUM_W'(price_ff);
   assign diff     = (price_ff >= ema_ff) ? (price_ff - ema_ff) : (ema_ff - price_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      sum_in       = sum_ff;
      fill_in      = fill_ff;
      wpos_in      = wpos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cnt_in       = cnt_ff;
      ema_in       = ema_ff;
      price_in     = price_ff;
      pos_in       = pos_ff;
      was_full_in  = was_full_ff;
      up_in        = up_ff;
      sma_in       = sma_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      out_sma_in   = out_sma_ff;
      out_ema_in   = out_ema_ff;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_valid) begin
               price_in    = req_price;
               // A shortened window may leave the write position beyond it.
               pos_in      = (N_W'(wpos_ff) >= n_eff) ? '0 : wpos_ff;
               was_full_in = (fill_ff >= n_eff);
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            // The ring read of the oldest word is registered here.
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in  = new_sum;
            wpos_in = (next_pos >= n_eff) ? '0 : next_pos[POS_W-1:0];
            if (!was_full_ff) begin
               fill_in = fill_inc;
            end
            if (was_full_ff || (fill_inc >= n_eff)) begin
               quot_in  = new_sum;
               rem_in   = '0;
               dvs_in   = DVS_W'(n_eff);
               cnt_in   = '0;
               state_in = ST_SMA_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SMA_DIV, ST_EMA_DIV: begin
            rem_in  = trial_ge ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], trial_ge};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = (state_ff == ST_SMA_DIV) ? ST_SMA_END : ST_EMA_END;
            end
         end
         ST_SMA_END: begin
            sma_in = quot_ff[PRICE_BITS-1:0];
            if (was_full_ff) begin
               // Rising: floor(2d / (N+1)); falling: ceil, via adding N.
               up_in    = (price_ff >= ema_ff);
               quot_in  = SUM_W'({diff, 1'b0})
                        + ((price_ff >= ema_ff) ? '0 : SUM_W'(n_eff));
               rem_in   = '0;
               dvs_in   = DVS_W'(n_eff) + DVS_W'(1);
               cnt_in   = '0;
               state_in = ST_EMA_DIV;
            end else begin
               ema_in   = quot_ff[PRICE_BITS-1:0];
               state_in = ST_DONE;
            end
         end
         ST_EMA_END: begin
            ema_in   = up_ff ? (ema_ff + quot_ff[PRICE_BITS-1:0])
                             : (ema_ff - quot_ff[PRICE_BITS-1:0]);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_sma_in   = sma_ff;
               out_ema_in   = ema_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A new window length starts the history afresh.
      if (csr_write_en) begin
         window_in = csr_window_length;
         sum_in    = '0;
         fill_in   = '0;
         wpos_in   = '0;
         ema_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         sum_ff       <= '0;
         fill_ff      <= '0;
         wpos_ff      <= '0;
         ema_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         wpos_ff      <= wpos_in;
         ema_ff       <= ema_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff    <= price_in;
      pos_ff      <= pos_in;
      was_full_ff <= was_full_in;
      up_ff       <= up_in;
      sma_ff      <= sma_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      out_sma_ff  <= out_sma_in;
      out_ema_ff  <= out_ema_in;
   end

   // Sample ring: one registered read and one write port.
   always_ff @(posedge clock) begin
      ring_rd_ff <= ring_mem[pos_ff];
      if (state_ff == ST_SUM) begin
         ring_mem[pos_ff] <= price_ff;
      end
   end

   assign req_stall               = (state_ff != ST_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_simple_average      = out_sma_ff;
   assign rsp_exponential_average = out_ema_ff;

`ifndef SYNTHESIS
   // The partial remainder never reaches the divisor while dividing.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SMA_DIV || state_ff == ST_EMA_DIV) |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

   // The fill count never exceeds the window.
   a_fill_in_window: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= n_eff)
      else $error("fill count beyond window length");

   // A result word is only raised by the sequencer handing it over.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the hand-over state");

   // The write position stays inside the window.
   a_wpos_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |=> (N_W'(wpos_ff) < n_eff))
      else $error("write position beyond window length");
`endif

endmodule

// File: verif/sea_average_checker.sv
// ----------------------------------------------------------------------------
// sea_average_checker: result checker for the moving average core
// Watches the price, result and window length ports, keeps its own copy of
// the sample ring, and compares every result word with the predicted pair.
// ----------------------------------------------------------------------------
module sea_average_checker
   import sea_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_write_en,
   input  logic [N_W-1:0]        csr_window_length,

   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [PRICE_BITS-1:0] req_price,

   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [PRICE_BITS-1:0] rsp_simple_average,
   input  logic [PRICE_BITS-1:0] rsp_exponential_average,

   output int                    outstanding,
   output int                    results_checked,
   output int                    fail_count
);

   typedef struct packed {
      logic [PRICE_BITS-1:0] simple;
      logic [PRICE_BITS-1:0] expo;
   } average_pair_type;

   logic [N_W-1:0]        window_reg;
   logic [PRICE_BITS-1:0] sample_ring [MAX_WINDOW];
   logic [SUM_W-1:0]      running_sum;
   int                    fill_level;
   int                    ring_pos;
   logic [PRICE_BITS-1:0] ema_level;

   average_pair_type      pending_averages [$];
   average_pair_type      got_pair;
   average_pair_type      want_pair;
   int                    failures;
   int                    checks;

   function automatic int window_size(input logic [N_W-1:0] w);
      if (w == 0)
         return 1;
      if (w > MAX_WINDOW)
         return MAX_WINDOW;
      return int'(w);
   endfunction

   // The step toward the new price is floored in both directions, so the
   // downward case rounds the magnitude up.
   function automatic logic [PRICE_BITS-1:0] ema_step(input logic [63:0] e,
                                                       input logic [63:0] p,
                                                       input int n);
      logic [63:0] d;
      d = 64'(n) + 64'd1;
      if (p >= e)
         return PRICE_BITS'(e + (64'd2 * (p - e)) / d);
      return PRICE_BITS'(e - (64'd2 * (e - p) + d - 64'd1) / d);
   endfunction

   function void clear_run();
      running_sum = '0;
      fill_level  = 0;
      ring_pos    = 0;
      ema_level   = '0;
   endfunction

   function void predict_averages(input logic [PRICE_BITS-1:0] price);
      int            n;
      int            pos;
      bit            was_full;
      logic [SUM_W-1:0] mean;
      average_pair_type pair;
      n   = window_size(window_reg);
      pos = (ring_pos >= n) ? 0 : ring_pos;
      was_full = (fill_level >= n);
      if (was_full)
         running_sum = running_sum - SUM_W'(sample_ring[pos]);
      sample_ring[pos] = price;
      running_sum = running_sum + SUM_W'(price);
      pos++;
      ring_pos = (pos >= n) ? 0 : pos;
      if (!was_full)
         fill_level++;
      if (fill_level < n)
         return;
      mean = running_sum / SUM_W'(n);
      if (was_full)
         ema_level = ema_step(64'(ema_level), 64'(price), n);
      else
         ema_level = PRICE_BITS'(mean);
      pair.simple = PRICE_BITS'(mean);
      pair.expo   = ema_level;
      pending_averages = {pending_averages, pair};
   endfunction

   function void check_result();
      got_pair.simple = rsp_simple_average;
      got_pair.expo   = rsp_exponential_average;
      if (pending_averages.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("checker: result word with nothing expected: sma %h ema %h",
                     got_pair.simple, got_pair.expo);
         return;
      end
      want_pair = pending_averages.pop_front();
      checks++;
      if (got_pair.simple !== want_pair.simple || got_pair.expo !== want_pair.expo) begin
         failures++;
         if (failures <= 10)
            $display("checker: mismatch: expected sma %h ema %h, got sma %h ema %h",
                     want_pair.simple, want_pair.expo, got_pair.simple, got_pair.expo);
      end
   endfunction

   // A result word leaving at the same edge as a new price word always belongs
   // to an earlier price, so it is compared before the new prediction.
   always @(posedge clock) begin
      if (reset) begin
         window_reg = WINDOW_RESET;
         clear_run();
         pending_averages.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result();
         if (csr_write_en) begin
            window_reg = csr_window_length;
            clear_run();
         end
         if (req_valid && !req_stall)
            predict_averages(req_price);
      end
      outstanding     <= pending_averages.size();
      results_checked <= checks;
      fail_count      <= failures;
   end

endmodule

// File: verif/sliding_and_exponential_average_core_tb.sv
// ----------------------------------------------------------------------------
// sliding_and_exponential_average_core_tb: testbench for the moving average
// Drives price words and window length settings into the core, stalls the
// result side at random, and lets the checker judge every result word.
// ----------------------------------------------------------------------------
module sliding_and_exponential_average_core_tb;
   import sea_pkg::*;

   // The slowest correct run is about 1700 words, each with the work of a
   // full-window word, a random sender gap and a receiver stall, plus a
   // settling pause per window setting. The limit is several times that.
   localparam int CYCLE_LIMIT  = 1_000_000;
   // The pause before a register write and at the end is comfortably longer
   // than the work of a full-window word plus a receiver stall.
   localparam int DRAIN_CYCLES = 120;
   localparam int RANDOM_WORDS = 1600;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [N_W-1:0]        csr_window_length = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PRICE_BITS-1:0] req_price = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b1;
   logic [PRICE_BITS-1:0] rsp_simple_average;
   logic [PRICE_BITS-1:0] rsp_exponential_average;

   int                    outstanding;
   int                    results_checked;
   int                    fail_count;
   int                    cycle_count = 0;
   int                    words_sent = 0;
   int                    window_writes = 0;
   bit                    calm = 1'b0;
   logic [PRICE_BITS-1:0] price_level = 32'h0001_0000;

   always #5 clock = ~clock;

   sliding_and_exponential_average_core u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .csr_write_en            (csr_write_en),
      .csr_window_length       (csr_window_length),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_price               (req_price),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_simple_average      (rsp_simple_average),
      .rsp_exponential_average (rsp_exponential_average)
   );

   sea_average_checker u_checker (
      .clock                   (clock),
      .reset                   (reset),
      .csr_write_en            (csr_write_en),
      .csr_window_length       (csr_window_length),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_price               (req_price),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_simple_average      (rsp_simple_average),
      .rsp_exponential_average (rsp_exponential_average),
      .outstanding             (outstanding),
      .results_checked         (results_checked),
      .fail_count              (fail_count)
   );

   // A watchdog: if the core hangs, the run still ends with a verdict.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sliding_and_exponential_average_core_tb: FAIL");
         $finish;
      end
   end

   // The result side. Before taking each result word it holds stall high for
   // a randomly drawn number of cycles, so that stalls land both while the
   // divider is busy and while a finished word waits in the output register.
   // In a calm phase it takes every word at once.
   initial begin
      int hold;
      @(posedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 12);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
      end
   end

   // Offers one price word after a random gap. When the gap is zero, valid
   // simply stays high and only the payload changes, so valid is never
   // lowered and raised within the same time step. The word is taken at the
   // first edge at which stall was low.
   task automatic send_price(input logic [PRICE_BITS-1:0] price);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_price <= price;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      words_sent++;
   endtask

   // Waits until every predicted result has been taken, then lets the core
   // finish any word that gives no result. The first edge is needed because
   // the checker's count is a registered copy of its queue size.
   task automatic wait_until_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A window length write also clears the history, so it is only made once
   // the core has gone quiet.
   task automatic set_window(input logic [N_W-1:0] length);
      wait_until_quiet();
      csr_write_en      <= 1'b1;
      csr_window_length <= length;
      @(posedge clock);
      csr_write_en      <= 1'b0;
      window_writes++;
   endtask

   // Prices are a mixture: the extremes, values just above zero and just
   // below full scale, fully random words, and a drifting market level that
   // makes the exponential average move both up and down in small steps.
   function automatic logic [PRICE_BITS-1:0] pick_price();
      case ($urandom_range(0, 9)) inside
         0: return '0;
         1: return '1;
         2: return PRICE_BITS'($urandom_range(0, 255));
         3: return '1 - PRICE_BITS'($urandom_range(0, 255));
         4, 5, 6: begin
            price_level = price_level + PRICE_BITS'($urandom_range(0, 4096))
                          - PRICE_BITS'(2048);
            return price_level;
         end
         default: return PRICE_BITS'($urandom);
      endcase
   endfunction

   // Most settings are short windows so that results come often; now and
   // then a long one, the largest one, zero, or a value above the maximum.
   function automatic logic [N_W-1:0] pick_window();
      case ($urandom_range(0, 15)) inside
         0:       return N_W'($urandom_range(MAX_WINDOW + 1, (1 << N_W) - 1));
         1:       return N_W'(MAX_WINDOW);
         2:       return '0;
         3, 4, 5: return N_W'($urandom_range(9, MAX_WINDOW - 1));
         default: return N_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic int effective_length(input logic [N_W-1:0] w);
      if (w == 0)
         return 1;
      if (w > MAX_WINDOW)
         return MAX_WINDOW;
      return int'(w);
   endfunction

   initial begin
      logic [N_W-1:0] length;
      int             phase_words;
      int             random_words;
      random_words = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. At the reset window length of 20, twenty full-scale
      // prices make the running sum its largest, and the following zero
      // pulls the exponential average down from the top.
      repeat (20) send_price('1);
      send_price('0);

      // A window of one: both averages follow the price exactly.
      set_window(N_W'(1));
      send_price('0);
      send_price('1);
      send_price(PRICE_BITS'(1));

      // A window length of zero behaves as a window of one.
      set_window('0);
      send_price(32'h8000_0000);
      send_price(32'h7FFF_FFFF);

      // Random part. Each phase picks a window, fills it, and then runs a
      // few dozen result-giving prices through it. The second to fourth phases
      // force a length above the maximum, the maximum itself and a length of two.
      while (random_words < RANDOM_WORDS) begin
         case (window_writes)
            3:       length = '1;
            4:       length = N_W'(MAX_WINDOW);
            5:       length = N_W'(2);
            default: length = pick_window();
         endcase
         set_window(length);
         calm = ($urandom_range(0, 4) == 0);
         phase_words = effective_length(length) + $urandom_range(10, 40);
         repeat (phase_words) begin
            send_price(pick_price());
            random_words++;
         end
      end

      wait_until_quiet();

      $display("Sent %0d price words over %0d window settings; %0d results compared.",
               words_sent, window_writes, results_checked);
      $display("Windows ranged from zero to above the maximum, with random gaps and stalls.");
      if (fail_count == 0)
         $display("sliding_and_exponential_average_core_tb: PASS");
      else
         $display("sliding_and_exponential_average_core_tb: FAIL");
      $finish;
   end

endmodule

// File: files.f
rtl/core/sea_pkg.sv
rtl/core/sliding_and_exponential_average_core.sv
verif/sea_average_checker.sv
verif/sliding_and_exponential_average_core_tb.sv
